[rtl/polynomial_arithmetic_unit_macros.svh]
// Assertion macros for the polynomial arithmetic unit.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef POLYNOMIAL_ARITHMETIC_UNIT_MACROS_SVH
`define POLYNOMIAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// ante holds in a cycle -> cons holds in the same cycle
`define PAU_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define PAU_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PAU_ASSERT_SAME(label, ck, rn, ante, cons, msg)
`define PAU_ASSERT_NEXT(label, ck, rn, ante, cons, msg)

`endif

`endif

[rtl/pau_pkg.sv]
// Shared types and constants of the polynomial arithmetic unit.
// Used by pau_ctrl, pau_datapath and polynomial_arithmetic_unit; no dependencies.
`default_nettype none

package pau_pkg;

  // request field widths
  localparam int MODE_W    = 3;
  localparam int IN_COEF_W = 16;
  localparam int ACC_W     = 40;
  localparam int POWER_W   = 5;

  // request modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUB_AB = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUB_BA = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MUL    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DERIV  = 3'd6;

  // datapath operation
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB_AB,
    OP_SUB_BA,
    OP_MUL,
    OP_DER
  } pau_op_t;

  // one issued step into the datapath pipeline
  typedef struct packed {
    logic    valid;
    pau_op_t op;
    logic    a_zero;  // A term lies beyond the stored length
    logic    b_zero;  // B term lies beyond the stored length
    logic    first;   // first contribution to this power: restart the sum
    logic    emit;    // last contribution: the sum is a result coefficient
    logic    last;    // constant term of the result run
  } pau_cmd_t;

  // coefficient store write enables
  typedef struct packed {
    logic we_a;
    logic we_b;
  } pau_wr_t;

endpackage

`default_nettype wire

[rtl/polynomial_arithmetic_unit.sv]
// Top level of the polynomial arithmetic unit: stream ports, controller and datapath.
// Depends on pau_pkg, pau_ctrl, pau_datapath and polynomial_arithmetic_unit_macros.svh.
//
// Channel  Dir  tdata                    tuser      tlast
// in_      in   coeff_in[15:0]           mode[2:0]  load_last
// out_     out  coeff_out[39:0],power    -          result_last
//
// A load request never holds off the next request; a mode 7 request is dropped.
// Add, subtract and derivative step one result term per cycle; multiply steps one
// multiply-accumulate per cycle on the single shared multiplier, lenA*lenB steps
// (256 at MAX_TERMS = 16); results then pass the read, stage and output registers.
// Reset needs no clearing pass; the unit takes requests in the cycle after reset.
// A stalled output register freezes the whole pipeline and the sequencer.
`default_nettype none

`include "polynomial_arithmetic_unit_macros.svh"

module polynomial_arithmetic_unit #(
  parameter int MAX_TERMS  = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] coeff_in
  input  logic [2:0]  in_tuser,   // [2:0] mode
  input  logic        in_tlast,   // load_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [39:0] coeff_out, [44:40] power, [47:45] zero
  output logic        out_tlast   // result_last
);
  import pau_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int PW = $clog2(2 * MAX_TERMS);

  pau_wr_t                 wr;
  pau_cmd_t                cmd;
  logic [AW-1:0]           wr_addr, addr_a, addr_b;
  logic [PW-1:0]           power, res_power;
  logic                    adv;
  logic signed [ACC_W-1:0] res_coeff;

  pau_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_mode  (in_tuser),
    .req_last  (in_tlast),
    .adv       (adv),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .power     (power)
  );

  pau_datapath #(
    .MAX_TERMS  (MAX_TERMS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_data   (signed'(in_tdata)),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .power     (power),
    .adv       (adv),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_coeff (res_coeff),
    .res_power (res_power),
    .res_last  (out_tlast)
  );

  // result packing
  assign out_tdata = {3'b000, POWER_W'(res_power), res_coeff};

  // the constant term closes every result run
  `PAU_ASSERT_SAME(a_last_is_const, clk, rst_n, out_tvalid && out_tlast, out_tdata[44:40] == 5'd0, "last result term is not the constant term")

  // a compute request holds off the next request: ready is low in the cycle after it
  `PAU_ASSERT_NEXT(a_compute_busy, clk, rst_n, in_tvalid && in_tready && in_tuser >= MODE_ADD && in_tuser <= MODE_DERIV, !in_tready, "ready after compute request")

  // a load request never blocks the next one
  `PAU_ASSERT_NEXT(a_load_ready, clk, rst_n, in_tvalid && in_tready && (in_tuser == MODE_LOAD_A || in_tuser == MODE_LOAD_B), in_tready, "load request dropped ready")

endmodule

`default_nettype wire

[rtl/pau_ctrl.sv]
// Controller of the polynomial arithmetic unit: load bookkeeping and step sequencer.
// Depends on pau_pkg; drives the command port of pau_datapath.
`default_nettype none

module pau_ctrl #(
  parameter int MAX_TERMS = 16,
  localparam int AW = $clog2(MAX_TERMS),
  localparam int CW = $clog2(MAX_TERMS + 1),
  localparam int PW = $clog2(2 * MAX_TERMS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [pau_pkg::MODE_W-1:0] req_mode,
  input  logic                      req_last,
  input  logic                      adv,
  output pau_pkg::pau_wr_t          wr,
  output logic [AW-1:0]             wr_addr,
  output pau_pkg::pau_cmd_t         cmd,
  output logic [AW-1:0]             addr_a,
  output logic [AW-1:0]             addr_b,
  output logic [PW-1:0]             power
);
  import pau_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          rs_a_r, rs_a_nxt, rs_b_r, rs_b_nxt;
  logic [CW-1:0] la_r, la_nxt, lb_r, lb_nxt;
  pau_op_t       op_r, op_nxt;
  logic          empty_r, empty_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [AW-1:0] i_r, i_nxt;

  logic          accept;
  logic [CW-1:0] cur_a, cur_b;
  logic [PW-1:0] la_p, lb_p, ca_p, cb_p, len, p_dec, i_hi, i_p;

  // lowest A index that meets a B term for output power x
  function automatic logic [PW-1:0] lo_of(input logic [PW-1:0] x,
                                          input logic [PW-1:0] lbv);
    logic [PW-1:0] r;
    r = '0;
    if (x >= lbv) r = x - lbv + PW'(1);
    return r;
  endfunction

  assign accept    = req_valid && (state_r == ST_IDLE);
  assign req_ready = (state_r == ST_IDLE);

  assign la_p  = PW'(la_r);
  assign lb_p  = PW'(lb_r);
  assign ca_p  = PW'(cnt_a_r);
  assign cb_p  = PW'(cnt_b_r);
  assign p_dec = p_r - PW'(1);
  assign i_p   = PW'(i_r);
  assign i_hi  = (p_r < la_p) ? p_r : la_p - PW'(1);
  assign cur_a = rs_a_r ? '0 : cnt_a_r;
  assign cur_b = rs_b_r ? '0 : cnt_b_r;

  // result length of the requested operation
  always_comb begin
    case (req_mode)
      MODE_MUL:   len = (ca_p == '0 || cb_p == '0) ? '0 : ca_p + cb_p - PW'(1);
      MODE_DERIV: len = (ca_p == '0) ? '0 : ca_p - PW'(1);
      default:    len = (ca_p > cb_p) ? ca_p : cb_p;
    endcase
  end

  // next state, store writes and step issue
  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    rs_a_nxt  = rs_a_r;
    rs_b_nxt  = rs_b_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    op_nxt    = op_r;
    empty_nxt = empty_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    wr        = '0;
    wr_addr   = '0;
    cmd       = '0;
    addr_a    = '0;
    addr_b    = '0;
    power     = p_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_mode)
            MODE_LOAD_A: begin
              if (cur_a < CW'(MAX_TERMS)) begin
                wr.we_a   = 1'b1;
                wr_addr   = AW'(cur_a);
                cnt_a_nxt = cur_a + CW'(1);
              end else begin
                cnt_a_nxt = cur_a;
              end
              rs_a_nxt = req_last;
            end
            MODE_LOAD_B: begin
              if (cur_b < CW'(MAX_TERMS)) begin
                wr.we_b   = 1'b1;
                wr_addr   = AW'(cur_b);
                cnt_b_nxt = cur_b + CW'(1);
              end else begin
                cnt_b_nxt = cur_b;
              end
              rs_b_nxt = req_last;
            end
            MODE_ADD, MODE_SUB_AB, MODE_SUB_BA, MODE_MUL, MODE_DERIV: begin
              state_nxt = ST_RUN;
              la_nxt    = cnt_a_r;
              lb_nxt    = cnt_b_r;
              case (req_mode)
                MODE_ADD:    op_nxt = OP_ADD;
                MODE_SUB_AB: op_nxt = OP_SUB_AB;
                MODE_SUB_BA: op_nxt = OP_SUB_BA;
                MODE_MUL:    op_nxt = OP_MUL;
                default:     op_nxt = OP_DER;
              endcase
              if (len == '0) begin
                empty_nxt = 1'b1;
                p_nxt     = '0;
                i_nxt     = '0;
                op_nxt    = OP_ADD;
              end else begin
                empty_nxt = 1'b0;
                p_nxt     = len - PW'(1);
                i_nxt     = AW'(lo_of(len - PW'(1), cb_p));
              end
            end
            default: begin
              // unused mode: dropped
            end
          endcase
        end
      end

      ST_RUN: begin
        cmd.valid = 1'b1;
        cmd.op    = op_r;
        if (empty_r) begin
          // nothing stored: a single zero constant term
          cmd.a_zero = 1'b1;
          cmd.b_zero = 1'b1;
          cmd.first  = 1'b1;
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
        end else begin
          case (op_r)
            OP_MUL: begin
              addr_a    = AW'(la_p - PW'(1) - i_p);
              addr_b    = AW'(lb_p - PW'(1) - p_r + i_p);
              cmd.first = (i_p == lo_of(p_r, lb_p));
              cmd.emit  = (i_p == i_hi);
              cmd.last  = (i_p == i_hi) && (p_r == '0);
            end
            OP_DER: begin
              addr_a    = AW'(la_p - PW'(2) - p_r);
              cmd.first = 1'b1;
              cmd.emit  = 1'b1;
              cmd.last  = (p_r == '0);
            end
            default: begin
              addr_a     = AW'(la_p - PW'(1) - p_r);
              addr_b     = AW'(lb_p - PW'(1) - p_r);
              cmd.a_zero = (p_r >= la_p);
              cmd.b_zero = (p_r >= lb_p);
              cmd.first  = 1'b1;
              cmd.emit   = 1'b1;
              cmd.last   = (p_r == '0);
            end
          endcase
        end
        // step on only when the pipeline moves
        if (adv) begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state_nxt = ST_IDLE;
            end else begin
              p_nxt = p_dec;
              i_nxt = AW'(lo_of(p_dec, lb_p));
            end
          end else begin
            i_nxt = i_r + AW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      rs_a_r  <= 1'b1;
      rs_b_r  <= 1'b1;
      la_r    <= '0;
      lb_r    <= '0;
      op_r    <= OP_ADD;
      empty_r <= 1'b0;
      p_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      rs_a_r  <= rs_a_nxt;
      rs_b_r  <= rs_b_nxt;
      la_r    <= la_nxt;
      lb_r    <= lb_nxt;
      op_r    <= op_nxt;
      empty_r <= empty_nxt;
      p_r     <= p_nxt;
      i_r     <= i_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pau_datapath.sv]
// Datapath of the polynomial arithmetic unit: coefficient stores, shared
// multiplier, accumulator and output register. Depends on pau_pkg.
`default_nettype none

module pau_datapath #(
  parameter int MAX_TERMS  = 16,
  parameter int COEF_WIDTH = 16,
  localparam int AW = $clog2(MAX_TERMS),
  localparam int PW = $clog2(2 * MAX_TERMS),
  localparam int MW = (COEF_WIDTH > 7) ? COEF_WIDTH : 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pau_pkg::pau_wr_t                    wr,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [pau_pkg::IN_COEF_W-1:0] wr_data,
  input  pau_pkg::pau_cmd_t                   cmd,
  input  logic [AW-1:0]                       addr_a,
  input  logic [AW-1:0]                       addr_b,
  input  logic [PW-1:0]                       power,
  output logic                                adv,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [pau_pkg::ACC_W-1:0]    res_coeff,
  output logic [PW-1:0]                       res_power,
  output logic                                res_last
);
  import pau_pkg::*;

  logic signed [COEF_WIDTH-1:0] mem_a [MAX_TERMS];
  logic signed [COEF_WIDTH-1:0] mem_b [MAX_TERMS];

  pau_cmd_t                     c1_r, c2_r;
  logic [PW-1:0]                p1_r, p2_r;
  logic signed [COEF_WIDTH-1:0] rd_a_r, rd_b_r;
  logic signed [ACC_W-1:0]      val2_r, acc_r, out_coeff_r;
  logic [PW-1:0]                out_power_r;
  logic                         out_last_r, out_valid_r;

  logic signed [COEF_WIDTH-1:0]    ea, eb;
  logic signed [MW-1:0]            mb;
  logic signed [COEF_WIDTH+MW-1:0] prod;
  logic signed [ACC_W-1:0]         val1, acc_sum;

  // whole pipeline moves when the output register can take a value
  assign adv = !out_valid_r || res_ready;

  // stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr.we_a) mem_a[wr_addr] <= COEF_WIDTH'(wr_data);
    if (wr.we_b) mem_b[wr_addr] <= COEF_WIDTH'(wr_data);
    if (adv) begin
      rd_a_r <= mem_a[addr_a];
      rd_b_r <= mem_b[addr_b];
      p1_r   <= power;
    end
  end

  // stage 1: operand select, shared multiplier, add/subtract
  assign ea   = c1_r.a_zero ? '0 : rd_a_r;
  assign eb   = c1_r.b_zero ? '0 : rd_b_r;
  assign mb   = (c1_r.op == OP_DER) ? MW'(p1_r) + MW'(1) : MW'(eb);
  assign prod = ea * mb;

  always_comb begin
    case (c1_r.op)
      OP_ADD:    val1 = ACC_W'(ea) + ACC_W'(eb);
      OP_SUB_AB: val1 = ACC_W'(ea) - ACC_W'(eb);
      OP_SUB_BA: val1 = ACC_W'(eb) - ACC_W'(ea);
      default:   val1 = ACC_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val2_r <= val1;
      p2_r   <= p1_r;
    end
  end

  // stage 2: accumulate the contributions to one power
  assign acc_sum = (c2_r.first ? '0 : acc_r) + val2_r;

  always_ff @(posedge clk) begin
    if (adv && c2_r.valid) acc_r <= acc_sum;
    if (adv && c2_r.valid && c2_r.emit) begin
      out_coeff_r <= acc_sum;
      out_power_r <= p2_r;
      out_last_r  <= c2_r.last;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r        <= '0;
      c2_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      c1_r        <= cmd;
      c2_r        <= c1_r;
      out_valid_r <= c2_r.valid && c2_r.emit;
    end
  end

  assign res_valid = out_valid_r;
  assign res_coeff = out_coeff_r;
  assign res_power = out_power_r;
  assign res_last  = out_last_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for polynomial_arithmetic_unit: streams load and compute requests and
// checks every result term against a scoreboard that predicts the same polynomials.
// Depends on pau_pkg and the polynomial_arithmetic_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import pau_pkg::*;

  localparam int TERMS = 16;
  localparam int REQUESTS = 170;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // one predicted result term
  typedef struct {
    logic [ACC_W-1:0]   coeff;
    logic [POWER_W-1:0] power;
    logic               last;
  } poly_term_t;

  // Keeps both polynomials as the block should and queues the terms each compute yields.
  class poly_scoreboard;
    logic signed [IN_COEF_W-1:0] terms[2][TERMS];  // index 0 is A, 1 is B
    int unsigned                 len[2];
    bit                          fresh[2];
    poly_term_t                  pending_terms[$];
    int unsigned                 errors;
    int unsigned                 checked;

    function new();
      len[0] = 0;
      len[1] = 0;
      fresh[0] = 1'b1;
      fresh[1] = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    // coefficient of x^p, zero past the stored length
    function longint coef_at(int sel, int p);
      if (p >= int'(len[sel])) return 0;
      return longint'(terms[sel][len[sel] - 1 - p]);
    endfunction

    function void push_term(longint c, int p);
      poly_term_t t;
      t.coeff = c[ACC_W-1:0];
      t.power = POWER_W'(p);
      t.last  = (p == 0);
      pending_terms.insert(pending_terms.size(), t);
    endfunction

    function void predict_run(logic [MODE_W-1:0] mode);
      int     n;
      longint acc[2*TERMS-1];
      longint c;
      if (mode == MODE_MUL) n = (len[0] == 0 || len[1] == 0) ? 0 : len[0] + len[1] - 1;
      else if (mode == MODE_DERIV) n = (len[0] == 0) ? 0 : len[0] - 1;
      else n = (len[0] > len[1]) ? len[0] : len[1];
      // nothing to emit: a lone zero constant term
      if (n == 0) begin
        push_term(0, 0);
        return;
      end
      if (mode == MODE_MUL) begin
        foreach (acc[k]) acc[k] = 0;
        for (int i = 0; i < int'(len[0]); i++)
          for (int j = 0; j < int'(len[1]); j++)
            acc[i+j] += coef_at(0, i) * coef_at(1, j);
      end
      for (int p = n - 1; p >= 0; p--) begin
        case (mode)
          MODE_ADD:    c = coef_at(0, p) + coef_at(1, p);
          MODE_SUB_AB: c = coef_at(0, p) - coef_at(1, p);
          MODE_SUB_BA: c = coef_at(1, p) - coef_at(0, p);
          MODE_MUL:    c = acc[p];
          default:     c = coef_at(0, p + 1) * longint'(p + 1);
        endcase
        push_term(c, p);
      end
    endfunction

    // called for every accepted input request
    function void note_request(logic [MODE_W-1:0] mode, logic [IN_COEF_W-1:0] coeff,
                               logic last);
      int sel;
      case (mode)
        MODE_LOAD_A, MODE_LOAD_B: begin
          sel = (mode == MODE_LOAD_B) ? 1 : 0;
          if (fresh[sel]) begin
            len[sel] = 0;
            fresh[sel] = 1'b0;
          end
          // terms past the store size are dropped, the mark still counts
          if (len[sel] < TERMS) begin
            terms[sel][len[sel]] = coeff;
            len[sel]++;
          end
          if (last) fresh[sel] = 1'b1;
        end
        MODE_ADD, MODE_SUB_AB, MODE_SUB_BA, MODE_MUL, MODE_DERIV: predict_run(mode);
        default: ;  // unused mode is dropped
      endcase
    endfunction

    // called for every accepted result term
    function void check_result(logic [ACC_W-1:0] coeff, logic [POWER_W-1:0] power,
                               logic last);
      poly_term_t want;
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result coeff=%0d power=%0d last=%0b",
                 $time, $signed(coeff), power, last);
        errors++;
        return;
      end
      want = pending_terms.pop_front();
      checked++;
      if (want.coeff !== coeff) begin
        $display("%0t: coeff mismatch, expected %0d, actual %0d",
                 $time, $signed(want.coeff), $signed(coeff));
        errors++;
      end
      if (want.power !== power) begin
        $display("%0t: power mismatch, expected %0d, actual %0d", $time, want.power, power);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  poly_scoreboard sb;
  bit             steady_tail;  // no idling on either side
  int unsigned    requests_sent;

  polynomial_arithmetic_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[39:0], out_tdata[44:40], out_tlast);
  end

  // result-side stalls: bursts low, stretches high
  initial begin : ready_driver
    int span;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 8);
      end else begin
        out_tready <= 1'b1;
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one request; called and returns just after a falling edge
  task automatic send_request(input logic [2:0] mode, input logic [15:0] coeff,
                              input logic last);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= coeff;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, coeff, last);
    if (mode != MODE_UNUSED) requests_sent++;
    @(negedge clk);
  endtask

  // a whole polynomial, marked on its constant term
  task automatic load_poly(input logic [2:0] mode, input int count, input bit extreme);
    for (int i = 0; i < count; i++)
      send_request(mode, extreme ? 16'h8000 : pick_coeff(), i == count - 1);
  endtask

  task automatic send_compute(input logic [2:0] mode);
    send_request(mode, 16'($urandom), 1'($urandom));
  endtask

  // stimulus
  initial begin : stimulus
    int n;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    steady_tail = 1'b0;
    requests_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stores and the unused mode
    send_request(MODE_UNUSED, 16'hffff, 1'b1);
    send_request(MODE_ADD, 16'h0000, 1'b0);
    send_request(MODE_MUL, 16'hffff, 1'b1);
    send_request(MODE_DERIV, 16'h0000, 1'b0);
    // A = 32767x - 32768, B = -32768
    send_request(MODE_LOAD_A, 16'h7fff, 1'b0);
    send_request(MODE_LOAD_A, 16'h8000, 1'b1);
    send_request(MODE_DERIV, 16'h0000, 1'b0);
    send_request(MODE_LOAD_B, 16'h8000, 1'b1);
    send_request(MODE_ADD, 16'h0000, 1'b0);
    send_request(MODE_SUB_AB, 16'h0000, 1'b0);
    send_request(MODE_SUB_BA, 16'h0000, 1'b0);
    send_request(MODE_MUL, 16'h0000, 1'b0);
    // derivative of a constant
    send_request(MODE_LOAD_A, 16'h0005, 1'b1);
    send_request(MODE_DERIV, 16'h0000, 1'b0);
    // unfinished load is used as is, then continued
    send_request(MODE_LOAD_B, 16'h0003, 1'b0);
    send_request(MODE_MUL, 16'h0000, 1'b0);
    send_request(MODE_LOAD_B, 16'hfffe, 1'b1);
    send_request(MODE_ADD, 16'h0000, 1'b0);

    // overlong A with the mark on a dropped term, full B, largest product
    load_poly(MODE_LOAD_A, TERMS + 2, 1'b1);
    load_poly(MODE_LOAD_B, TERMS, 1'b1);
    send_compute(MODE_MUL);
    send_compute(MODE_DERIV);

    // random mix: mostly whole polynomials then a compute, some noise
    while (requests_sent < REQUESTS) begin
      steady_tail = (requests_sent >= REQUESTS - 30);
      case ($urandom_range(0, 9))
        0: send_request(MODE_UNUSED, pick_coeff(), 1'($urandom));
        1: send_request(3'($urandom_range(MODE_LOAD_A, MODE_LOAD_B)), pick_coeff(), 1'b0);
        2: send_compute(3'($urandom_range(MODE_ADD, MODE_DERIV)));
        default: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(TERMS - 2, TERMS + 2)
                                           : $urandom_range(1, 5);
          load_poly(3'($urandom_range(MODE_LOAD_A, MODE_LOAD_B)), n, 1'b0);
          send_compute(3'($urandom_range(MODE_ADD, MODE_DERIV)));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // drain, then wait for stray results
    while (sb.pending_terms.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("ran %0d requests through loads, all five operations and dropped mode,",
             requests_sent);
    $display("checked %0d result terms with %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pau_pkg.sv
rtl/pau_ctrl.sv
rtl/pau_datapath.sv
rtl/polynomial_arithmetic_unit.sv
test/testbench.sv
